// ===== rtl/flt_pkg.sv =====
// Shared types and constants for the direct-mapped flow table.
// Used by flt_update and flow_table_level_replace; no dependencies.
`default_nettype none

package flt_pkg;

  localparam int NUM_BINS = 1024;
  localparam int ADDR_W   = $clog2(NUM_BINS);
  localparam int CUR_W    = $clog2(NUM_BINS + 1);

  localparam logic [2:0] FN_GET     = 3'd0;
  localparam logic [2:0] FN_ADD     = 3'd1;
  localparam logic [2:0] FN_ADD_LVL = 3'd2;
  localparam logic [2:0] FN_SET_LVL = 3'd3;
  localparam logic [2:0] FN_DELETE  = 3'd4;
  localparam logic [2:0] FN_CLEAR   = 3'd5;
  localparam logic [2:0] FN_NEXT    = 3'd6;

  typedef struct packed {
    logic        occ;
    logic [31:0] key;
    logic [31:0] count;
    logic [7:0]  level;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]        func;
    logic              inb;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       key;
    logic [31:0]       delta;
    logic [7:0]        level;
  } req_t;

  typedef struct packed {
    logic        wr_en;
    entry_t      wr_entry;
    logic        bump;
    logic        found;
    logic [31:0] value;
    logic [7:0]  level;
    logic [31:0] key;
    logic        sampled;
  } upd_res_t;

endpackage

`default_nettype wire

// ===== rtl/flt_ram.sv =====
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module flt_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/flt_update.sv =====
// Read-modify-write logic for one bin: decides the new entry, the collision
// bump and the result fields. Depends on flt_pkg.
`default_nettype none

module flt_update (
  input  flt_pkg::req_t     req,
  input  flt_pkg::entry_t   rd,
  input  logic              repl,
  output flt_pkg::upd_res_t res
);
  import flt_pkg::*;

  logic        occ;
  logic        match;
  logic [31:0] sum;
  logic        keep;

  assign occ   = req.inb & rd.occ;
  assign match = occ & (rd.key == req.key);
  assign sum   = rd.count + req.delta;
  // A resident entry survives a set-level eviction when it ranks higher, or
  // ties with live traffic.
  assign keep  = (rd.level > req.level) ||
                 ((rd.level == req.level) && (rd.count != 32'd0));

  always_comb begin
    res = '0;
    res.wr_entry = rd;
    case (req.func)
      FN_GET: begin
        if (match) begin
          res.found   = 1'b1;
          res.value   = rd.count;
          res.level   = rd.level;
          res.key     = rd.key;
          res.sampled = (rd.count != 32'd0);
        end
      end
      FN_ADD: begin
        if (req.inb) begin
          if (!occ) begin
            res.wr_en    = 1'b1;
            res.wr_entry = '{occ: 1'b1, key: req.key, count: req.delta, level: 8'd0};
          end else if (match) begin
            res.wr_en          = 1'b1;
            res.wr_entry.count = sum;
          end else begin
            res.bump = 1'b1;
          end
        end
      end
      FN_ADD_LVL: begin
        if (req.inb) begin
          if (!occ) begin
            res.wr_en    = 1'b1;
            res.wr_entry = '{occ: 1'b1, key: req.key, count: req.delta, level: req.level};
          end else if (match) begin
            res.wr_en          = 1'b1;
            res.wr_entry.count = sum;
            res.wr_entry.level = req.level;
          end else begin
            res.bump = 1'b1;
            if (repl && (rd.level < req.level)) begin
              res.wr_en    = 1'b1;
              res.wr_entry = '{occ: 1'b1, key: req.key, count: req.delta,
                               level: req.level};
            end
          end
        end
      end
      FN_SET_LVL: begin
        if (req.inb) begin
          if (!occ) begin
            if (repl && (req.level != 8'd0)) begin
              res.wr_en    = 1'b1;
              res.wr_entry = '{occ: 1'b1, key: req.key, count: 32'd0, level: req.level};
            end
          end else if (match) begin
            res.wr_en          = 1'b1;
            res.wr_entry.level = req.level;
          end else if (req.level != 8'd0) begin
            res.bump = 1'b1;
            if (repl && !keep) begin
              res.wr_en    = 1'b1;
              res.wr_entry = '{occ: 1'b1, key: req.key, count: 32'd0, level: req.level};
            end
          end
        end
      end
      FN_DELETE: begin
        if (match) begin
          res.wr_en        = 1'b1;
          res.wr_entry.occ = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/flow_table_level_replace.sv =====
// Direct-mapped flow table. Get, add, add+level, set level and delete read the bin from
// memory, then modify and write it back and raise out_valid; a new request is accepted
// only once the last has finished (busy low). Next examines bins one per cycle on the
// memory read port. Clear all writes one bin per cycle, then raises out_valid. After
// reset a clearing pass over all NUM_BINS bins runs with busy high; results cannot be
// stalled. Depends on flt_pkg, flt_ram and flt_update.
`default_nettype none

module flow_table_level_replace (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [9:0]  in_bin_index,
  input  logic [31:0] in_flow_key,
  input  logic [31:0] in_delta,
  input  logic [7:0]  in_level_in,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_value_out,
  output logic [7:0]  out_level_out,
  output logic [31:0] out_key_out,
  output logic        out_sampled,
  output logic [31:0] out_collision_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import flt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [31:0]       collisions_r, collisions_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [CUR_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0] chk_addr_r, chk_addr_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_report_r, clr_report_nxt;
  logic              replacement_on_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [31:0]       out_value_r, out_value_nxt;
  logic [7:0]        out_level_r, out_level_nxt;
  logic [31:0]       out_key_r, out_key_nxt;
  logic              out_sampled_r, out_sampled_nxt;
  logic [31:0]       out_coll_r, out_coll_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  upd_res_t          upd;
  logic              cfg_wr;

  flt_ram #(
    .DATA_W(ENTRY_W),
    .DEPTH (NUM_BINS),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  flt_update u_update (
    .req (req_r),
    .rd  (ram_rdata),
    .repl(replacement_on_r),
    .res (upd)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, replacement_on_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replacement_on_r <= 1'b0;
    end else if (cfg_wr) begin
      replacement_on_r <= pwdata[0];
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    collisions_nxt  = collisions_r;
    cursor_nxt      = cursor_r;
    scan_addr_nxt   = scan_addr_r;
    chk_vld_nxt     = 1'b0;
    chk_addr_nxt    = chk_addr_r;
    clr_addr_nxt    = clr_addr_r;
    clr_report_nxt  = clr_report_r;
    out_valid_nxt   = 1'b0;
    out_found_nxt   = 1'b0;
    out_value_nxt   = 32'd0;
    out_level_nxt   = 8'd0;
    out_key_nxt     = 32'd0;
    out_sampled_nxt = 1'b0;
    out_coll_nxt    = collisions_r;
    ram_re          = 1'b0;
    ram_raddr       = ADDR_W'(in_bin_index);
    ram_we          = 1'b0;
    ram_waddr       = req_r.addr;
    ram_wdata       = upd.wr_entry;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt.func  = in_func;
          req_nxt.inb   = (32'(in_bin_index) < 32'(NUM_BINS));
          req_nxt.addr  = ADDR_W'(in_bin_index);
          req_nxt.key   = in_flow_key;
          req_nxt.delta = in_delta;
          req_nxt.level = in_level_in;
          case (in_func)
            FN_CLEAR: begin
              state_nxt      = ST_CLEAR;
              clr_addr_nxt   = '0;
              clr_report_nxt = 1'b1;
              collisions_nxt = 32'd0;
              cursor_nxt     = '0;
            end
            FN_NEXT: begin
              state_nxt     = ST_SCAN;
              scan_addr_nxt = cursor_r;
            end
            default: begin
              ram_re    = 1'b1;
              state_nxt = ST_EXEC;
            end
          endcase
        end
      end
      ST_EXEC: begin
        ram_we          = upd.wr_en;
        collisions_nxt  = collisions_r + 32'(upd.bump);
        out_valid_nxt   = 1'b1;
        out_found_nxt   = upd.found;
        out_value_nxt   = upd.value;
        out_level_nxt   = upd.level;
        out_key_nxt     = upd.key;
        out_sampled_nxt = upd.sampled;
        out_coll_nxt    = collisions_nxt;
        state_nxt       = ST_IDLE;
      end
      ST_SCAN: begin
        // Reads are issued one bin per cycle; each is checked when its data returns from the registered read port.
        ram_raddr = scan_addr_r[ADDR_W-1:0];
        if (scan_addr_r < CUR_W'(NUM_BINS)) begin
          ram_re        = 1'b1;
          chk_vld_nxt   = 1'b1;
          chk_addr_nxt  = scan_addr_r[ADDR_W-1:0];
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
        if (chk_vld_r && ram_rdata.occ) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_value_nxt = ram_rdata.count;
          out_key_nxt   = ram_rdata.key;
          cursor_nxt    = CUR_W'(chk_addr_r) + 1'b1;
          chk_vld_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!ram_re) begin
          out_valid_nxt = 1'b1;
          cursor_nxt    = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(NUM_BINS - 1)) begin
          state_nxt      = ST_IDLE;
          clr_report_nxt = 1'b0;
          out_valid_nxt  = clr_report_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      collisions_r <= 32'd0;
      cursor_r     <= '0;
      chk_vld_r    <= 1'b0;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      collisions_r <= collisions_nxt;
      cursor_r     <= cursor_nxt;
      chk_vld_r    <= chk_vld_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    if (out_valid_nxt) begin
      out_found_r   <= out_found_nxt;
      out_value_r   <= out_value_nxt;
      out_level_r   <= out_level_nxt;
      out_key_r     <= out_key_nxt;
      out_sampled_r <= out_sampled_nxt;
      out_coll_r    <= out_coll_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_value_out       = out_value_r;
  assign out_level_out       = out_level_r;
  assign out_key_out         = out_key_r;
  assign out_sampled         = out_sampled_r;
  assign out_collision_count = out_coll_r;

`ifndef SYNTHESIS
  // A single-bin request raises out_valid after its bin has been read and updated.
  a_rmw_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FN_CLEAR && in_func != FN_NEXT) |=> ##1 out_valid)
    else $error("single-bin request did not answer after two cycles");

  // The walk only reads the table.
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("table written during a walk");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(NUM_BINS))
    else $error("walk cursor beyond the last bin");

  // The collision count either steps by one or is cleared.
  a_coll_step: assert property (@(posedge clk) disable iff (!rst_n)
    (collisions_r != $past(collisions_r)) |->
      (collisions_r == $past(collisions_r) + 32'd1 || collisions_r == 32'd0))
    else $error("collision count jumped");
`endif

endmodule

`default_nettype wire
